>>> rtl/core/pms_pkg.sv
// Shared types, register codes and saturation helper for the particle motion step
`default_nettype none
package pms_pkg;

   localparam int FIELD_W  = 32;
   localparam int TIME_W   = 64;
   localparam int STEP_W   = 16;
   localparam int SAT_IN_W = 56;
   localparam int AXES     = 3;
   localparam int AXIS_Y   = 1;

   typedef enum logic [2:0] {
      REG_NOW_TIME    = 3'd0,
      REG_STEP_TIME   = 3'd1,
      REG_GRAVITY     = 3'd2,
      REG_DRAG        = 3'd3,
      REG_WIND_X      = 3'd4,
      REG_WIND_Y      = 3'd5,
      REG_WIND_Z      = 3'd6,
      REG_WIND_WINDOW = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] pos_z;
      logic signed [FIELD_W-1:0] vel_x;
      logic signed [FIELD_W-1:0] vel_y;
      logic signed [FIELD_W-1:0] vel_z;
      logic [TIME_W-1:0]         birth_time;
      logic [TIME_W-1:0]         life_span;
   } req_payload_type;

   typedef struct packed {
      logic                      expired;
      logic signed [FIELD_W-1:0] new_pos_x;
      logic signed [FIELD_W-1:0] new_pos_y;
      logic signed [FIELD_W-1:0] new_pos_z;
      logic signed [FIELD_W-1:0] new_vel_x;
      logic signed [FIELD_W-1:0] new_vel_y;
      logic signed [FIELD_W-1:0] new_vel_z;
   } rsp_payload_type;

   typedef struct packed {
      logic [TIME_W-1:0]         now_time;
      logic [STEP_W-1:0]         step_time;
      logic signed [FIELD_W-1:0] gravity_accel;
      logic signed [FIELD_W-1:0] drag_coeff;
      logic signed [FIELD_W-1:0] wind_x;
      logic signed [FIELD_W-1:0] wind_y;
      logic signed [FIELD_W-1:0] wind_z;
      logic [TIME_W-1:0]         wind_window;
   } cfg_type;

   // after age subtract and the step products
   typedef struct packed {
      logic [AXES-1:0][FIELD_W-1:0] pos;
      logic [AXES-1:0][FIELD_W-1:0] vel;
      logic [TIME_W-1:0]            age;
      logic [TIME_W-1:0]            life_span;
      logic [AXES-1:0][47:0]        wind_prod;
      logic [47:0]                  grav_prod;
      logic [47:0]                  drag_prod;
   } s1_type;

   // after rounding, gravity terms and drag factor
   typedef struct packed {
      logic                         expired;
      logic [AXES-1:0][FIELD_W-1:0] pos;
      logic [AXES-1:0][33:0]        t;
      logic [AXES-1:0][FIELD_W-1:0] v1;
      logic [AXES-1:0][32:0]        wind_r;
      logic [34:0]                  factor;
   } s2_type;

   // after the second multiply
   typedef struct packed {
      logic                         expired;
      logic [AXES-1:0][FIELD_W-1:0] pos;
      logic [AXES-1:0][50:0]        td;
      logic [AXES-1:0][32:0]        wind_r;
      logic [AXES-1:0][50:0]        vf_hi;
      logic [AXES-1:0][48:0]        vf_lo;
   } s3_type;

   function automatic logic [FIELD_W-1:0] sat_coord(input logic signed [SAT_IN_W-1:0] x,
                                                    input int w);
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      logic signed [SAT_IN_W-1:0] r;
      hi = (SAT_IN_W'(1) <<< (w - 1)) - SAT_IN_W'(1);
      lo = -hi - SAT_IN_W'(1);
      if (x > hi) begin
         r = hi;
      end else if (x < lo) begin
         r = lo;
      end else begin
         r = x;
      end
      return r[FIELD_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/particle_motion_step.sv
// Top level of the particle motion step: register port and four-stage pipeline
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+------------------
//  req     | req_valid, req_ready           | in        | req_payload_type
//  rsp     | rsp_valid, rsp_ready           | out       | rsp_payload_type
//  csr     | psel penable pwrite paddr ...  | in / out  | 64-bit registers
//
//  One request per cycle while the result is not stalled; a taken request passes s1, s2, s3, s4.
//  The pipeline depth is set by the two multiply stages, each followed by an add stage.
//  Reset clears the valid bits and the configuration registers.
//  A stalled result holds every occupied stage behind it; empty stages still fill.
`default_nettype none
module particle_motion_step #(
   parameter int COORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pms_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pms_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [5:0]               paddr,
   input  logic [63:0]              pwdata,
   output logic [63:0]              prdata,
   output logic                     pready
);
   import pms_pkg::*;

   localparam int SAT_W = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 16) ? 16 : COORD_BITS);

   cfg_type cfg;
   logic    mid_valid;
   logic    mid_ready;
   s2_type  mid_data;

   pms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pms_prep #(.SAT_W(SAT_W)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   pms_integ #(.SAT_W(SAT_W)) u_integ (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

   a_expired_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.expired) |->
         (rsp_payload.new_pos_x == '0 && rsp_payload.new_pos_y == '0 &&
          rsp_payload.new_pos_z == '0 && rsp_payload.new_vel_x == '0 &&
          rsp_payload.new_vel_y == '0 && rsp_payload.new_vel_z == '0))
      else $error("expired result carries motion data");

endmodule
`default_nettype wire

>>> rtl/core/pms_csr.sv
// Configuration register file behind the APB-style port
`default_nettype none
module pms_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [5:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready,
   output pms_pkg::cfg_type cfg
);
   import pms_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[5:3]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_NOW_TIME:    cfg_in.now_time      = pwdata;
            REG_STEP_TIME:   cfg_in.step_time     = pwdata[STEP_W-1:0];
            REG_GRAVITY:     cfg_in.gravity_accel = pwdata[FIELD_W-1:0];
            REG_DRAG:        cfg_in.drag_coeff    = pwdata[FIELD_W-1:0];
            REG_WIND_X:      cfg_in.wind_x        = pwdata[FIELD_W-1:0];
            REG_WIND_Y:      cfg_in.wind_y        = pwdata[FIELD_W-1:0];
            REG_WIND_Z:      cfg_in.wind_z        = pwdata[FIELD_W-1:0];
            REG_WIND_WINDOW: cfg_in.wind_window   = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_NOW_TIME:    prdata = cfg_ff.now_time;
         REG_STEP_TIME:   prdata = {48'd0, cfg_ff.step_time};
         REG_GRAVITY:     prdata = {32'd0, cfg_ff.gravity_accel};
         REG_DRAG:        prdata = {32'd0, cfg_ff.drag_coeff};
         REG_WIND_X:      prdata = {32'd0, cfg_ff.wind_x};
         REG_WIND_Y:      prdata = {32'd0, cfg_ff.wind_y};
         REG_WIND_Z:      prdata = {32'd0, cfg_ff.wind_z};
         REG_WIND_WINDOW: prdata = cfg_ff.wind_window;
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   a_step_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && index == REG_STEP_TIME) |=> cfg_ff.step_time == $past(pwdata[STEP_W-1:0]))
      else $error("step_time write lost");

endmodule
`default_nettype wire

>>> rtl/core/pms_prep.sv
// Front pipeline: age and step products, then rounding, gravity and drag factor
`default_nettype none
module pms_prep #(
   parameter int SAT_W = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pms_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pms_pkg::req_payload_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pms_pkg::s2_type          out_data
);
   import pms_pkg::*;

   logic   s1_valid_ff, s1_valid_in;
   logic   s2_valid_ff, s2_valid_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic   s1_adv, s2_adv;

   assign s2_adv    = !s2_valid_ff || out_ready;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   assign in_ready  = s1_adv;
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

   assign s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      logic signed [47:0] d48;
      logic signed [47:0] g48;
      logic signed [47:0] dr48;
      logic signed [47:0] w48 [AXES];
      d48   = {32'd0, cfg.step_time};
      g48   = {{16{cfg.gravity_accel[FIELD_W-1]}}, cfg.gravity_accel};
      dr48  = {{16{cfg.drag_coeff[FIELD_W-1]}}, cfg.drag_coeff};
      w48[0] = {{16{cfg.wind_x[FIELD_W-1]}}, cfg.wind_x};
      w48[1] = {{16{cfg.wind_y[FIELD_W-1]}}, cfg.wind_y};
      w48[2] = {{16{cfg.wind_z[FIELD_W-1]}}, cfg.wind_z};
      s1_in.pos[0]    = in_data.pos_x;
      s1_in.pos[1]    = in_data.pos_y;
      s1_in.pos[2]    = in_data.pos_z;
      s1_in.vel[0]    = in_data.vel_x;
      s1_in.vel[1]    = in_data.vel_y;
      s1_in.vel[2]    = in_data.vel_z;
      s1_in.age       = cfg.now_time - in_data.birth_time;
      s1_in.life_span = in_data.life_span;
      s1_in.grav_prod = g48 * d48;
      s1_in.drag_prod = dr48 * d48;
      for (int a = 0; a < AXES; a++) begin
         s1_in.wind_prod[a] = w48[a] * d48;
      end
   end

   always_comb begin
      logic signed [49:0] gneg;
      logic signed [49:0] g17;
      logic signed [49:0] g16;
      logic signed [48:0] dsum;
      logic signed [48:0] wsum;
      logic signed [33:0] gt17;
      logic signed [33:0] gt16;
      logic signed [33:0] vel34;
      logic signed [SAT_IN_W-1:0] v1w;
      logic               wind_on;
      gneg    = -$signed({{2{s1_ff.grav_prod[47]}}, s1_ff.grav_prod});
      g17     = gneg + (50'sd1 <<< 16);
      g16     = gneg + (50'sd1 <<< 15);
      dsum    = $signed({s1_ff.drag_prod[47], s1_ff.drag_prod}) + (49'sd1 <<< 15);
      wind_on = s1_ff.age < cfg.wind_window;
      s2_in.expired = s1_ff.age > s1_ff.life_span;
      s2_in.factor  = 35'sd65536 - {{2{dsum[48]}}, dsum[48:16]};
      for (int a = 0; a < AXES; a++) begin
         gt17  = (a == AXIS_Y) ? {g17[49], g17[49:17]} : 34'sd0;
         gt16  = (a == AXIS_Y) ? g16[49:16] : 34'sd0;
         vel34 = {{2{s1_ff.vel[a][FIELD_W-1]}}, s1_ff.vel[a]};
         wsum  = $signed({s1_ff.wind_prod[a][47], s1_ff.wind_prod[a]}) + (49'sd1 <<< 15);
         v1w   = {{(SAT_IN_W-34){1'b0}}, 34'd0};
         v1w   = SAT_IN_W'($signed(vel34 + gt16));
         s2_in.pos[a]    = s1_ff.pos[a];
         s2_in.t[a]      = vel34 + gt17;
         s2_in.v1[a]     = sat_coord(v1w, SAT_W);
         s2_in.wind_r[a] = wind_on ? wsum[48:16] : 33'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_ff <= s1_in;
      end
      if (s2_adv) begin
         s2_ff <= s2_in;
      end
   end

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_adv) |=> s2_valid_ff)
      else $error("request dropped between front stages");

endmodule
`default_nettype wire

>>> rtl/core/pms_integ.sv
// Back pipeline: step and drag products, then position and velocity sums with saturation
`default_nettype none
module pms_integ #(
   parameter int SAT_W = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pms_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  pms_pkg::s2_type          in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pms_pkg::rsp_payload_type out_data
);
   import pms_pkg::*;

   logic            s3_valid_ff, s3_valid_in;
   logic            s4_valid_ff, s4_valid_in;
   s3_type          s3_ff, s3_in;
   rsp_payload_type s4_ff, s4_in;
   logic            s3_adv, s4_adv;

   assign s4_adv    = !s4_valid_ff || out_ready;
   assign s3_adv    = !s3_valid_ff || s4_adv;
   assign in_ready  = s3_adv;
   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

   assign s3_valid_in = s3_adv ? in_valid : s3_valid_ff;
   assign s4_valid_in = s4_adv ? s3_valid_ff : s4_valid_ff;

   always_comb begin
      logic signed [50:0] d51;
      logic signed [50:0] t51;
      logic signed [50:0] v51;
      logic signed [50:0] fhi51;
      logic signed [48:0] v49;
      logic signed [48:0] flo49;
      d51   = {35'd0, cfg.step_time};
      fhi51 = {{32{in_data.factor[34]}}, in_data.factor[34:16]};
      flo49 = {33'd0, in_data.factor[15:0]};
      s3_in.expired = in_data.expired;
      for (int a = 0; a < AXES; a++) begin
         t51 = {{17{in_data.t[a][33]}}, in_data.t[a]};
         v51 = {{19{in_data.v1[a][FIELD_W-1]}}, in_data.v1[a]};
         v49 = {{17{in_data.v1[a][FIELD_W-1]}}, in_data.v1[a]};
         s3_in.pos[a]    = in_data.pos[a];
         s3_in.wind_r[a] = in_data.wind_r[a];
         s3_in.td[a]     = t51 * d51;
         s3_in.vf_hi[a]  = v51 * fhi51;
         s3_in.vf_lo[a]  = v49 * flo49;
      end
   end

   always_comb begin
      logic signed [50:0]         tdr;
      logic signed [49:0]         vlr;
      logic signed [SAT_IN_W-1:0] p;
      logic signed [SAT_IN_W-1:0] v;
      logic [AXES-1:0][FIELD_W-1:0] np;
      logic [AXES-1:0][FIELD_W-1:0] nv;
      for (int a = 0; a < AXES; a++) begin
         tdr = $signed(s3_ff.td[a]) + (51'sd1 <<< 15);
         vlr = $signed({s3_ff.vf_lo[a][48], s3_ff.vf_lo[a]}) + (50'sd1 <<< 15);
         p   = $signed({{(SAT_IN_W-FIELD_W){s3_ff.pos[a][FIELD_W-1]}}, s3_ff.pos[a]})
             + $signed({{(SAT_IN_W-35){tdr[50]}}, tdr[50:16]})
             - $signed({{(SAT_IN_W-33){s3_ff.wind_r[a][32]}}, s3_ff.wind_r[a]});
         v   = $signed({{(SAT_IN_W-51){s3_ff.vf_hi[a][50]}}, s3_ff.vf_hi[a]})
             + $signed({{(SAT_IN_W-34){vlr[49]}}, vlr[49:16]});
         np[a] = s3_ff.expired ? '0 : sat_coord(p, SAT_W);
         nv[a] = s3_ff.expired ? '0 : sat_coord(v, SAT_W);
      end
      s4_in.expired   = s3_ff.expired;
      s4_in.new_pos_x = np[0];
      s4_in.new_pos_y = np[1];
      s4_in.new_pos_z = np[2];
      s4_in.new_vel_x = nv[0];
      s4_in.new_vel_y = nv[1];
      s4_in.new_vel_z = nv[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_ff <= s3_in;
      end
      if (s4_adv) begin
         s4_ff <= s4_in;
      end
   end

   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && !out_ready && s3_valid_ff) |=> (s3_valid_ff && $stable(s3_ff)))
      else $error("back stage moved while output stalled");

   a_s3_moves: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s4_adv) |=> s4_valid_ff)
      else $error("request dropped before output stage");

endmodule
`default_nettype wire
